// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the schedule list (the sequencer includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SISL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// A condition that implies another one in the same cycle.
`define SISL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// A condition that implies another one in the following cycle.
`define SISL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/sisl_pkg.sv =====
// Package with the types and constants of the sorted schedule list.
package sisl_pkg;

   // Default list depth.
   localparam int MAX_ENTRIES_DEF = 16;

   // Command codes of an input item.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   // Status codes of a result item.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DUMP  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   // One stored schedule entry, 33 bits.
   typedef struct packed {
      logic [7:0] tag;
      logic [2:0] day;
      logic [4:0] start_hour;
      logic [5:0] start_minute;
      logic [4:0] end_hour;
      logic [5:0] end_minute;
   } entry_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_DMP_RD,
      ST_DMP_OUT,
      ST_RESP
   } state_type;

   // Request from the sequencer to load the output register.
   typedef struct packed {
      logic       load;
      status_type status;
      logic       last;
      logic       use_entry;
   } rsp_load_type;

   // Contents of the output register.
   typedef struct packed {
      status_type status;
      entry_type  entry;
      logic       last;
   } rsp_type;

endpackage

// ===== hdl/sisl_if.sv =====
// Channel interfaces for the command input and the result output.
interface sisl_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] subject_tag;
   logic [2:0] week_day;
   logic [4:0] start_hour;
   logic [5:0] start_minute;
   logic [4:0] end_hour;
   logic [5:0] end_minute;

   modport source (
      output valid, command, subject_tag, week_day, start_hour, start_minute,
             end_hour, end_minute,
      input  ready
   );
   modport sink (
      input  valid, command, subject_tag, week_day, start_hour, start_minute,
             end_hour, end_minute,
      output ready
   );
endinterface

interface sisl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] out_tag;
   logic [2:0] out_day;
   logic [4:0] out_start_hour;
   logic [5:0] out_start_minute;
   logic [4:0] out_end_hour;
   logic [5:0] out_end_minute;
   logic       last;

   modport source (
      output valid, status, out_tag, out_day, out_start_hour, out_start_minute,
             out_end_hour, out_end_minute, last,
      input  ready
   );
   modport sink (
      input  valid, status, out_tag, out_day, out_start_hour, out_start_minute,
             out_end_hour, out_end_minute, last,
      output ready
   );
endinterface

// ===== hdl/sorted_insert_schedule_list_top.sv =====
// Sorted schedule list: insert keeps weekday order, dump streams the list in order.
// Insert: each entry moved up passes a read state and a compare state; then the new entry is written.
// Full insert and empty dump: the single result is loaded in the response state, once the output is free.
// Dump: each stored entry passes a read state and an output state, as the entry memory reads registered.
// One command is worked at a time; the output register frees the result side.
// Synchronous active-high reset empties the list; memory contents are not cleared.
module sorted_insert_schedule_list_top import sisl_pkg::*; #(
   parameter int MaxEntries = MAX_ENTRIES_DEF,
   localparam int AddrW = $clog2(MaxEntries)
) (
   input logic         clock,
   input logic         reset,
   sisl_req_if.sink    req_ch,
   sisl_rsp_if.source  rsp_ch
);

   entry_type        req_entry;
   rsp_load_type     rsp_load;
   logic             out_free;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   entry_type        wr_data;
   logic [AddrW-1:0] rd_addr;
   entry_type        rd_data;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // Gather the input payload into an entry.
   always_comb begin
      req_entry.tag          = req_ch.subject_tag;
      req_entry.day          = req_ch.week_day;
      req_entry.start_hour   = req_ch.start_hour;
      req_entry.start_minute = req_ch.start_minute;
      req_entry.end_hour     = req_ch.end_hour;
      req_entry.end_minute   = req_ch.end_minute;
   end

   sisl_ctrl #(.MaxEntries(MaxEntries)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_command (req_ch.command),
      .req_entry   (req_entry),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   sisl_store #(.MaxEntries(MaxEntries)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: free when empty or when its result transfers this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load.load) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = rsp_load.status;
         rsp_in.entry  = rsp_load.use_entry ? rd_data : '0;
         rsp_in.last   = rsp_load.last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Drive the result channel.
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_ff.status;
   assign rsp_ch.out_tag          = rsp_ff.entry.tag;
   assign rsp_ch.out_day          = rsp_ff.entry.day;
   assign rsp_ch.out_start_hour   = rsp_ff.entry.start_hour;
   assign rsp_ch.out_start_minute = rsp_ff.entry.start_minute;
   assign rsp_ch.out_end_hour     = rsp_ff.entry.end_hour;
   assign rsp_ch.out_end_minute   = rsp_ff.entry.end_minute;
   assign rsp_ch.last             = rsp_ff.last;

endmodule

// ===== hdl/sisl_store.sv =====
// Entry memory: one write port and one read port with registered read data.
module sisl_store import sisl_pkg::*; #(
   parameter int MaxEntries = MAX_ENTRIES_DEF,
   localparam int AddrW = $clog2(MaxEntries)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MaxEntries];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sisl_ctrl.sv =====
// Sequencer: walks the list to insert and dump, with one weekday comparator that orders inserts.
`include "assert_macros.svh"

module sisl_ctrl import sisl_pkg::*; #(
   parameter int MaxEntries = MAX_ENTRIES_DEF,
   localparam int AddrW = $clog2(MaxEntries),
   localparam int CntW  = $clog2(MaxEntries + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   input  entry_type        req_entry,
   input  logic             out_free,
   output rsp_load_type     rsp_load,
   output logic             wr_en,
   output logic [AddrW-1:0] wr_addr,
   output entry_type        wr_data,
   output logic [AddrW-1:0] rd_addr,
   input  entry_type        rd_data
);

   state_type             state_ff, state_in;
   logic      [CntW-1:0]  count_ff, count_in;
   logic      [CntW-1:0]  idx_ff, idx_in;
   entry_type             new_ff, new_in;
   status_type            status_ff, status_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  day_ge;
   logic      [CntW-1:0]  idx_dec;
   logic      [CntW-1:0]  idx_inc;
   logic                  last_dump;

   // Shared unit: the weekday compare, plus index step and list bounds.
   assign day_ge    = rd_data.day >= new_ff.day;
   assign idx_dec   = idx_ff - CntW'(1);
   assign idx_inc   = idx_ff + CntW'(1);
   assign last_dump = idx_inc == count_ff;
   assign full      = count_ff == CntW'(MaxEntries);
   assign empty     = count_ff == '0;
   assign accept    = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_DUMP) begin
                  state_in = empty ? ST_RESP : ST_DMP_RD;
               end else begin
                  state_in = full ? ST_RESP : ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            state_in = (idx_ff == '0) ? ST_RESP : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = day_ge ? ST_INS_RD : ST_RESP;
         end
         ST_DMP_RD: begin
            state_in = ST_DMP_OUT;
         end
         ST_DMP_OUT: begin
            if (out_free) begin
               state_in = last_dump ? ST_IDLE : ST_DMP_RD;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: handshake, memory ports and result loads.
   always_comb begin
      req_ready          = 1'b0;
      wr_en              = 1'b0;
      wr_addr            = idx_ff[AddrW-1:0];
      wr_data            = new_ff;
      rd_addr            = idx_ff[AddrW-1:0];
      rsp_load.load      = 1'b0;
      rsp_load.status    = status_ff;
      rsp_load.last      = 1'b1;
      rsp_load.use_entry = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_INS_RD: begin
            // Fetch the entry below the hole; at the head the new entry goes in.
            rd_addr = idx_dec[AddrW-1:0];
            if (idx_ff == '0) begin
               wr_en = 1'b1;
            end
         end
         ST_INS_CMP: begin
            // Move the entry up one place, or drop the new entry into the hole.
            wr_en   = 1'b1;
            wr_data = day_ge ? rd_data : new_ff;
         end
         ST_DMP_OUT: begin
            rsp_load.load      = out_free;
            rsp_load.status    = STATUS_DUMP;
            rsp_load.last      = last_dump;
            rsp_load.use_entry = 1'b1;
         end
         ST_RESP: begin
            rsp_load.load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Next values of the count, the index and the held command.
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      new_in    = new_ff;
      status_in = status_ff;
      if (accept) begin
         new_in = req_entry;
         if (req_command == CMD_DUMP) begin
            idx_in    = '0;
            status_in = empty ? STATUS_EMPTY : STATUS_DUMP;
         end else begin
            idx_in    = count_ff;
            status_in = full ? STATUS_FULL : STATUS_OK;
         end
      end
      if (state_ff == ST_INS_RD && idx_ff == '0) begin
         count_in = count_ff + CntW'(1);
      end
      if (state_ff == ST_INS_CMP) begin
         if (day_ge) begin
            idx_in = idx_dec;
         end else begin
            count_in = count_ff + CntW'(1);
         end
      end
      if (state_ff == ST_DMP_OUT && out_free) begin
         idx_in = idx_inc;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Held command payload.
   always_ff @(posedge clock) begin
      new_ff    <= new_in;
      status_ff <= status_in;
   end

   // The fill count never passes the depth.
   `SISL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(MaxEntries))
   // A write never lands beyond the first free place after the current fill.
   `SISL_ASSERT_IMPL(a_write_in_fill, clock, reset, wr_en, idx_ff <= count_ff)
   // A dump leaves the list unchanged.
   `SISL_ASSERT_NEXT(a_dump_keeps_count, clock, reset,
      state_ff == ST_DMP_RD || state_ff == ST_DMP_OUT, count_ff == $past(count_ff))
   // A result is only loaded when the output register can take it.
   `SISL_ASSERT_IMPL(a_load_when_free, clock, reset, rsp_load.load, out_free)

endmodule
